// File: src/mpfc_pkg.sv
package mpfc_pkg;

    // Field and register widths.
    localparam int WORD_W  = 32;
    localparam int TB_W    = 3;
    localparam int IDX_W   = 3;
    localparam int PROD_W  = 2 * WORD_W;

    // Channel lanes: red, green, blue, alpha.
    localparam int NUM_LANES = 4;

    // One quotient bit per divider stage.
    localparam int DIV_STEPS = WORD_W;

    // Lane latency: field register, product register, divider, channel register.
    localparam int LANE_LAT = DIV_STEPS + 3;

    // Default destination depth in bits.
    localparam int DEST_DEPTH_DEF = 32;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [TB_W-1:0]   t_tbytes;
    typedef logic [IDX_W-1:0]  t_idx;

    // Configuration register indexes.
    localparam t_idx REG_SRC_RED   = 3'd0;
    localparam t_idx REG_SRC_GREEN = 3'd1;
    localparam t_idx REG_SRC_BLUE  = 3'd2;
    localparam t_idx REG_SRC_ALPHA = 3'd3;
    localparam t_idx REG_TEXEL_B   = 3'd4;
    localparam t_idx REG_DST_RED   = 3'd5;
    localparam t_idx REG_DST_GREEN = 3'd6;
    localparam t_idx REG_DST_BLUE  = 3'd7;

    // Standard 8-bit channel masks.
    localparam t_word MASK_B0 = 32'h0000_00ff;
    localparam t_word MASK_B1 = 32'h0000_ff00;
    localparam t_word MASK_B2 = 32'h00ff_0000;
    localparam t_word MASK_B3 = 32'hff00_0000;

    // Texel size that the fast path needs.
    localparam t_tbytes FULL_TEXEL_BYTES = 3'd4;

    // Path selection, derived from the configuration.
    typedef struct packed {
        logic fast;   // four-byte 8-bit pass-through
        logic keep;   // pass unchanged rather than swap bytes 0 and 2
    } t_path;

    // Position of the lowest set bit; 31 for an empty mask.
    function automatic logic [4:0] f_low_bit(input t_word m);
        logic [4:0] s;
        s = 5'd31;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    // All-ones mask of the destination depth.
    function automatic t_word f_depth_mask(input int depth);
        logic [PROD_W-1:0] m;
        m = (PROD_W'(1) << depth) - PROD_W'(1);
        return (depth >= WORD_W) ? '1 : m[WORD_W-1:0];
    endfunction

endpackage

// File: src/mpfc_div.sv
module mpfc_div
    import mpfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PROD_W-1:0] i_dividend,
    input  t_word             i_divisor,
    output t_word             o_quot
);

    // Partial remainder and the dividend bits still to come, with the
    // quotient bits filling in from the bottom as the low word shifts out.
    t_word r_rem [DIV_STEPS];
    t_word r_low [DIV_STEPS];

    // The quotient fits in one word, so the high word of the dividend is
    // already below the divisor and serves as the first remainder.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        t_word       rem_in;
        t_word       low_in;
        logic [32:0] trial;
        t_word       diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_in = i_dividend[PROD_W-1:WORD_W];
            assign low_in = i_dividend[WORD_W-1:0];
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
        end

        // Restoring step: bring down one bit, subtract where it fits.
        // The new remainder is below the divisor, so one word holds it.
        assign trial = {rem_in, low_in[WORD_W-1]};
        assign ge    = (trial >= {1'b0, i_divisor});
        assign diff  = trial[WORD_W-1:0] - i_divisor;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff : trial[WORD_W-1:0];
                r_low[k] <= {low_in[WORD_W-2:0], ge};
            end
        end
    end

    assign o_quot = r_low[DIV_STEPS-1];

endmodule

// File: src/mpfc_lane.sv
module mpfc_lane
    import mpfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_texel,
    input  t_word i_smask,
    input  t_word i_dmask,
    output t_word o_chan
);

    logic [4:0]        ss;
    logic [4:0]        ds;
    t_word             smax;
    t_word             dmax;
    t_word             quot;
    t_word             n_chan;
    t_word             r_field;
    logic [PROD_W-1:0] r_prod;
    t_word             r_chan;

    // The user must hold masks steady while transactions are in flight (the block
    // does not enforce it); their derived shifts and maxima are read directly at every stage.
    assign ss   = f_low_bit(i_smask);
    assign ds   = f_low_bit(i_dmask);
    assign smax = i_smask >> ss;
    assign dmax = i_dmask >> ds;

    // Extract the source field and scale it up by the destination maximum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_field <= (i_texel & i_smask) >> ss;
            r_prod  <= PROD_W'(r_field) * PROD_W'(dmax);
        end
    end

    // Divide by the source maximum.
    mpfc_div u_div (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_prod),
        .i_divisor  (smax),
        .o_quot     (quot)
    );

    // Place the scaled value; empty masks take their fixed values.
    always_comb begin
        if (i_dmask == '0) begin
            n_chan = '0;
        end else if (i_smask == '0) begin
            n_chan = i_dmask;
        end else begin
            n_chan = quot << ds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

// File: src/mpfc_merge.sv
module mpfc_merge
    import mpfc_pkg::*;
#(
    parameter int DEST_DEPTH = DEST_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_word i_chan [NUM_LANES],
    input  t_word i_texel,
    input  t_path i_path,
    output logic  o_en,
    output logic  o_valid,
    input  logic  i_ready,
    output t_word o_data
);

    localparam t_word DEPTH_MASK = f_depth_mask(DEST_DEPTH);

    t_word pixel;
    t_word ored;
    t_word fast_val;
    logic  take;
    logic  pop;
    t_word r_out;
    logic  r_out_vld;
    t_word r_skid;
    logic  r_skid_vld;

    // Combine the lanes, or pick the pass-through value.
    always_comb begin
        ored = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            ored = ored | i_chan[i];
        end
        fast_val = i_path.keep ? i_texel
                               : {i_texel[31:24], i_texel[7:0], i_texel[15:8], i_texel[23:16]};
        pixel = i_path.fast ? fast_val : (ored & DEPTH_MASK);
    end

    // The pipeline moves only while the skid register is empty.
    assign o_en = !r_skid_vld;
    assign take = o_en && i_vld;
    assign pop  = !r_out_vld || i_ready;

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= take;
            end
        end else if (take) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_vld ? r_skid : pixel;
        end else if (take) begin
            r_skid <= pixel;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// File: src/mask_pixel_format_converter.sv
// Channel     Direction  Transaction                 Payload
// s_axis      in         tvalid & tready             tdata[31:0] texel_in
// m_axis      out        tvalid & tready             tdata[31:0] pixel_out
// cfg         in         i_cfg_wen                   i_cfg_idx selects, i_cfg_wdata value
//
// One texel is accepted per clock while the skid register is empty; its pixel passes
// through 35 lane registers, the first loaded at the accepting edge, then the
// output register. Most of those lane registers are the 32-stage restoring
// divider in each channel lane, one quotient bit per stage.
// Reset is synchronous and active low; it loads the default masks.
// A stall on the output fills a skid register, after which the input stalls.
module mask_pixel_format_converter
    import mpfc_pkg::*;
#(
    parameter int DEST_DEPTH = DEST_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // [31:0] texel_in
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [31:0]  o_m_axis_tdata,   // [31:0] pixel_out
    input  logic         i_cfg_wen,
    input  t_idx         i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata
);

    localparam t_word DEPTH_MASK = f_depth_mask(DEST_DEPTH);

    t_word   r_src_red;
    t_word   r_src_green;
    t_word   r_src_blue;
    t_word   r_src_alpha;
    t_tbytes r_texel_bytes;
    t_word   r_dst_red;
    t_word   r_dst_green;
    t_word   r_dst_blue;

    logic    en;
    t_word   texel;
    t_word   dst_alpha;
    t_path   path;
    t_word   smask [NUM_LANES];
    t_word   dmask [NUM_LANES];
    t_word   chan  [NUM_LANES];

    logic [LANE_LAT-1:0] r_vld;
    t_word               r_tx [LANE_LAT];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_red     <= MASK_B0;
            r_src_green   <= MASK_B1;
            r_src_blue    <= MASK_B2;
            r_src_alpha   <= MASK_B3;
            r_texel_bytes <= FULL_TEXEL_BYTES;
            r_dst_red     <= MASK_B2;
            r_dst_green   <= MASK_B1;
            r_dst_blue    <= MASK_B0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_SRC_RED:   r_src_red     <= i_cfg_wdata;
                REG_SRC_GREEN: r_src_green   <= i_cfg_wdata;
                REG_SRC_BLUE:  r_src_blue    <= i_cfg_wdata;
                REG_SRC_ALPHA: r_src_alpha   <= i_cfg_wdata;
                REG_TEXEL_B:   r_texel_bytes <= i_cfg_wdata[TB_W-1:0];
                REG_DST_RED:   r_dst_red     <= i_cfg_wdata;
                REG_DST_GREEN: r_dst_green   <= i_cfg_wdata;
                REG_DST_BLUE:  r_dst_blue    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Keep only the bytes that belong to the texel; sizes above four act as four.
    always_comb begin
        case (r_texel_bytes)
            3'd0:    texel = '0;
            3'd1:    texel = {24'd0, i_s_axis_tdata[7:0]};
            3'd2:    texel = {16'd0, i_s_axis_tdata[15:0]};
            3'd3:    texel = {8'd0, i_s_axis_tdata[23:0]};
            default: texel = i_s_axis_tdata;
        endcase
    end

    // Path choice and the destination alpha mask follow from the configuration.
    assign path.fast = (r_texel_bytes >= FULL_TEXEL_BYTES) && (r_src_green == MASK_B1)
                    && ((r_src_red == MASK_B0) || (r_src_red == MASK_B2))
                    && (r_dst_red == MASK_B2) && (r_dst_green == MASK_B1)
                    && (r_dst_blue == MASK_B0);
    assign path.keep = (r_src_red == MASK_B2);
    assign dst_alpha = DEPTH_MASK & ~(r_dst_red | r_dst_green | r_dst_blue);

    assign smask[0] = r_src_red;
    assign smask[1] = r_src_green;
    assign smask[2] = r_src_blue;
    assign smask[3] = r_src_alpha;
    assign dmask[0] = r_dst_red;
    assign dmask[1] = r_dst_green;
    assign dmask[2] = r_dst_blue;
    assign dmask[3] = dst_alpha;

    assign o_s_axis_tready = en;

    // Valid bits and the texel for the pass-through travel beside the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LANE_LAT-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx[0] <= texel;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_tx[i] <= r_tx[i-1];
            end
        end
    end

    // One lane per channel.
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        mpfc_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_texel (texel),
            .i_smask (smask[l]),
            .i_dmask (dmask[l]),
            .o_chan  (chan[l])
        );
    end

    // Merge the lanes and hold the result for the output side.
    mpfc_merge #(
        .DEST_DEPTH (DEST_DEPTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[LANE_LAT-1]),
        .i_chan  (chan),
        .i_texel (r_tx[LANE_LAT-1]),
        .i_path  (path),
        .o_en    (en),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
